// ===== rtl/ctq_pkg.sv =====
// ----------------------------------------------------------------------------
// ctq_pkg
// Shared types, codes and helpers of the CAN transmit queue with retry
// handling and bus-off tracking.
// ----------------------------------------------------------------------------
package ctq_pkg;

  localparam int unsigned QueueDepth = 8;
  localparam int unsigned FillW      = $clog2(QueueDepth + 1);

  localparam int unsigned IdW      = 29;
  localparam int unsigned LenW     = 4;
  localparam int unsigned PayloadW = 64;
  localparam int unsigned RetryW   = 4;
  localparam int unsigned ErrW     = 8;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned SentW    = 32;
  localparam int unsigned RecW     = 16;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned QFillW   = 4;

  localparam logic [LenW-1:0]  MaxLen        = LenW'(8);
  localparam logic [ErrW-1:0]  ErrPassiveLvl = ErrW'(128);
  localparam logic [ErrW-1:0]  ErrBusOffLvl  = ErrW'(255);
  localparam logic [RecW-1:0]  RecResetVal   = RecW'(100);
  localparam logic [RetryW-1:0] RetryResetVal = RetryW'(3);

  typedef enum logic [1:0] {
    KindEnqueue = 2'd0,
    KindDirect  = 2'd1,
    KindService = 2'd2,
    KindAbort   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    OutcomeOk    = 2'd0,
    OutcomeBusy  = 2'd1,
    OutcomeError = 2'd2,
    OutcomeOther = 2'd3
  } outcome_e;

  typedef enum logic [1:0] {
    RcOk     = 2'd0,
    RcBusOff = 2'd1,
    RcFull   = 2'd2,
    RcFailed = 2'd3
  } rc_e;

  typedef enum logic [1:0] {
    LinkActive  = 2'd0,
    LinkPassive = 2'd1,
    LinkBusOff  = 2'd2
  } link_e;

  typedef enum logic [2:0] {
    HlthActive  = 3'b001,
    HlthPassive = 3'b010,
    HlthBusOff  = 3'b100
  } health_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgRecovery = 1'b0,
    CfgRetry    = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [IdW-1:0]      id;
    logic [LenW-1:0]     len;
    logic [PayloadW-1:0] payload;
    logic                extended;
    logic                remote;
  } frame_t;

  typedef struct packed {
    frame_t              frame;
    logic [RetryW-1:0]   retries;
  } slot_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic bump;
  } cell_ctrl_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic [IdW-1:0]      frame_id;
    logic [LenW-1:0]     frame_len;
    logic [PayloadW-1:0] frame_payload;
    logic                frame_extended;
    logic                frame_remote;
    logic [1:0]          attempt_outcome;
    logic [TimeW-1:0]    now_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0]          result_code;
    logic [1:0]          link_state;
    logic [ErrW-1:0]     tx_error_count;
    logic [QFillW-1:0]   queue_fill;
    logic                head_valid;
    logic [IdW-1:0]      head_id;
    logic [LenW-1:0]     head_len;
    logic [PayloadW-1:0] head_payload;
    logic                head_extended;
    logic                head_remote;
    logic                dropped_frame;
    logic [SentW-1:0]    sent_total;
  } out_item_t;

  function automatic logic [RetryW-1:0] retry_inc(input logic [RetryW-1:0] r);
    logic [RetryW-1:0] res;
    res = (r == '1) ? r : r + RetryW'(1);
    return res;
  endfunction

endpackage

// ===== rtl/ctq_if.sv =====
// ----------------------------------------------------------------------------
// ctq_if
// Valid/ready channels of the transmit queue: input item, result item and
// configuration write.
// ----------------------------------------------------------------------------
interface ctq_in_if import ctq_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ctq_out_if import ctq_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ctq_cfg_if import ctq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/can_tx_queue_retry_busoff.sv =====
// ----------------------------------------------------------------------------
// can_tx_queue_retry_busoff
// CAN transmit queue as a shifting row of slot cells, with retry counting,
// transmit error counter and bus-off recovery.
// ----------------------------------------------------------------------------
// a result is registered and offered in the cycle after its item is accepted
// throughput: one item per cycle while the result side is ready; the next item is taken as the result leaves
// the head frame always sits in cell 0, a pop shifts the row by one cell
// reset clears fill, counters, link state and registers to defaults at once
// slot contents are not reset, only filled slots are ever presented
module can_tx_queue_retry_busoff import ctq_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  ctq_in_if.sink     in_i,
  ctq_out_if.source  out_o,
  ctq_cfg_if.sink    cfg_i
);

  logic [RecW-1:0]   rec_time_q;
  logic [RetryW-1:0] retry_lim_q;

  logic [FillW-1:0] fill_q, fill_d;
  logic [ErrW-1:0]  err_q, err_d;
  health_e          health_q, health_d;
  logic [TimeW-1:0] stamp_q, stamp_d;
  logic [SentW-1:0] sent_q, sent_d;
  logic             out_valid_q;
  rc_e              rc_q, rc_d;
  logic             drop_q, drop_d;

  logic       accept;
  logic       pop;
  logic       bump;
  frame_t     new_frame;
  slot_t      slots [QueueDepth];
  slot_t      nexts [QueueDepth];
  cell_ctrl_t ctrls [QueueDepth];
  logic [RetryW-1:0] head_retry_nx;
  logic [TimeW-1:0]  elapsed;
  in_item_t   it;

  assign it     = in_i.data;
  assign accept = in_i.valid && in_i.ready;
  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign cfg_i.ready = 1'b1;

  always_comb begin
    new_frame          = '0;
    new_frame.id       = it.frame_id;
    new_frame.len      = (it.frame_len > MaxLen) ? MaxLen : it.frame_len;
    new_frame.payload  = it.frame_payload;
    new_frame.extended = it.frame_extended;
    new_frame.remote   = it.frame_remote;
  end

  assign head_retry_nx = retry_inc(slots[0].retries);
  assign elapsed       = it.now_ms - stamp_q;

  always_comb begin
    fill_d   = fill_q;
    err_d    = err_q;
    health_d = health_q;
    stamp_d  = stamp_q;
    sent_d   = sent_q;
    rc_d     = RcOk;
    drop_d   = 1'b0;
    pop      = 1'b0;
    bump     = 1'b0;
    unique case (kind_e'(it.kind))
      KindEnqueue: begin
        if (fill_q >= FillW'(QueueDepth)) begin
          rc_d = RcFull;
        end else begin
          fill_d = fill_q + FillW'(1);
        end
      end
      KindDirect: begin
        if (health_q == HlthBusOff) begin
          rc_d = RcBusOff;
        end else if (it.attempt_outcome == OutcomeOk) begin
          sent_d = sent_q + SentW'(1);
        end else begin
          rc_d = RcFailed;
          if (err_q != ErrBusOffLvl) begin
            err_d = err_q + ErrW'(1);
          end
          if (err_d >= ErrPassiveLvl) begin
            health_d = HlthPassive;
          end
          if (err_d == ErrBusOffLvl) begin
            health_d = HlthBusOff;
            stamp_d  = it.now_ms;
          end
        end
      end
      KindService: begin
        if (health_q == HlthBusOff) begin
          rc_d = RcBusOff;
          if (elapsed >= TimeW'(rec_time_q)) begin
            fill_d   = '0;
            err_d    = '0;
            health_d = HlthActive;
          end
        end else if (fill_q != '0) begin
          if (it.attempt_outcome == OutcomeOk) begin
            pop    = 1'b1;
            fill_d = fill_q - FillW'(1);
            sent_d = sent_q + SentW'(1);
          end else if (it.attempt_outcome != OutcomeBusy) begin
            if (head_retry_nx >= retry_lim_q) begin
              pop    = 1'b1;
              drop_d = 1'b1;
              fill_d = fill_q - FillW'(1);
            end else begin
              bump = 1'b1;
            end
          end
        end
      end
      KindAbort: begin
        fill_d = '0;
      end
      default: begin
        fill_d = fill_q;
      end
    endcase
  end

  for (genvar i = 0; i < QueueDepth; i++) begin : g_cell
    if (i == QueueDepth - 1) begin : g_last
      assign nexts[i] = slots[i];
    end else begin : g_mid
      assign nexts[i] = slots[i+1];
    end

    always_comb begin
      ctrls[i].load  = accept && (kind_e'(it.kind) == KindEnqueue) &&
                       (fill_q == FillW'(i));
      ctrls[i].shift = accept && pop;
      ctrls[i].bump  = accept && bump && (i == 0);
    end

    ctq_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrls[i]),
      .new_frame_i (new_frame),
      .next_i      (nexts[i]),
      .slot_o      (slots[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_time_q  <= RecResetVal;
      retry_lim_q <= RetryResetVal;
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CfgRecovery: rec_time_q  <= cfg_i.data[RecW-1:0];
        CfgRetry:    retry_lim_q <= cfg_i.data[RetryW-1:0];
        default:     rec_time_q  <= rec_time_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      err_q       <= '0;
      health_q    <= HlthActive;
      stamp_q     <= '0;
      sent_q      <= '0;
      out_valid_q <= 1'b0;
      rc_q        <= RcOk;
      drop_q      <= 1'b0;
    end else begin
      if (accept) begin
        fill_q   <= fill_d;
        err_q    <= err_d;
        health_q <= health_d;
        stamp_q  <= stamp_d;
        sent_q   <= sent_d;
        rc_q     <= rc_d;
        drop_q   <= drop_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  link_e link;
  logic  head_vld;

  always_comb begin
    unique case (health_q)
      HlthActive:  link = LinkActive;
      HlthPassive: link = LinkPassive;
      HlthBusOff:  link = LinkBusOff;
      default:     link = LinkActive;
    endcase
  end

  assign head_vld = (fill_q != '0);

  always_comb begin
    out_o.data                = '0;
    out_o.data.result_code    = rc_q;
    out_o.data.link_state     = link;
    out_o.data.tx_error_count = err_q;
    out_o.data.queue_fill     = QFillW'(fill_q);
    out_o.data.head_valid     = head_vld;
    out_o.data.dropped_frame  = drop_q;
    out_o.data.sent_total     = sent_q;
    if (head_vld) begin
      out_o.data.head_id       = slots[0].frame.id;
      out_o.data.head_len      = slots[0].frame.len;
      out_o.data.head_payload  = slots[0].frame.payload;
      out_o.data.head_extended = slots[0].frame.extended;
      out_o.data.head_remote   = slots[0].frame.remote;
    end
  end

  assign out_o.valid = out_valid_q;

endmodule

// ===== rtl/ctq_cell.sv =====
// ----------------------------------------------------------------------------
// ctq_cell
// One queue slot: loads a new frame, takes its neighbor's frame on a pop,
// or bumps its retry count.
// ----------------------------------------------------------------------------
module ctq_cell import ctq_pkg::*; (
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  frame_t     new_frame_i,
  input  slot_t      next_i,
  output slot_t      slot_o
);

  slot_t slot_q, slot_d;

  always_comb begin
    slot_d = slot_q;
    if (ctrl_i.load) begin
      slot_d.frame   = new_frame_i;
      slot_d.retries = '0;
    end else if (ctrl_i.shift) begin
      slot_d = next_i;
    end else if (ctrl_i.bump) begin
      slot_d.retries = retry_inc(slot_q.retries);
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  assign slot_o = slot_q;

endmodule
